// ===== hw/rtl/arpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package arpc_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int IP_W        = 32;
    localparam int MAC_W       = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 48;

    localparam logic [1:0] ACT_RESOLVE = 2'd0;
    localparam logic [1:0] ACT_SET     = 2'd1;
    localparam logic [1:0] ACT_FRAME   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 2'd1;

    localparam logic [1:0] CMD_NOP    = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_LEARN  = 2'd2;

    localparam logic [10:0] MIN_FRAME_BYTES = 11'd28;
    localparam logic [15:0] HW_TYPE_ETH     = 16'h0001;
    localparam logic [15:0] PROTO_IPV4      = 16'h0800;
    localparam logic [7:0]  HW_LEN_ETH      = 8'd6;
    localparam logic [7:0]  PROT_LEN_IPV4   = 8'd4;
    localparam logic [15:0] OP_REQUEST      = 16'd1;

    typedef struct packed {
        logic [1:0]       action;
        logic [IP_W-1:0]  ip_addr;
        logic [MAC_W-1:0] mac_addr;
        logic [10:0]      frame_length;
        logic [15:0]      hw_type;
        logic [15:0]      prot_type;
        logic [7:0]       hw_len;
        logic [7:0]       prot_len;
        logic [15:0]      opcode;
        logic [IP_W-1:0]  tgt_ip;
    } item_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic             frame_ok;
        logic             reply;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } cmd_t;

    typedef struct packed {
        logic             hit;
        logic [MAC_W-1:0] mac_out;
        logic             frame_accepted;
        logic             reply_valid;
        logic [MAC_W-1:0] reply_mac;
        logic [IP_W-1:0]  reply_ip;
    } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/arpc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module arpc_front (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire arpc_pkg::item_t                s_item,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [arpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [arpc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output arpc_pkg::cmd_t                      q_cmd,
    output logic                                q_push,
    input  wire                                 q_full
);
    import arpc_pkg::*;

    logic [IP_W-1:0] own_ip_reg;
    logic            frame_ok;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign q_push    = s_valid && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_ip_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_OWN_IP:  own_ip_reg <= cfg_data[IP_W-1:0];
                // own MAC writes are accepted but not stored
                REG_OWN_MAC: ;
                default:     ;
            endcase
        end
    end

    assign frame_ok = (s_item.frame_length >= MIN_FRAME_BYTES) &&
                      (s_item.hw_type == HW_TYPE_ETH) &&
                      (s_item.prot_type == PROTO_IPV4) &&
                      (s_item.hw_len == HW_LEN_ETH) &&
                      (s_item.prot_len == PROT_LEN_IPV4);

    always_comb begin
        q_cmd          = '0;
        q_cmd.ip       = s_item.ip_addr;
        q_cmd.mac      = s_item.mac_addr;
        case (s_item.action)
            ACT_RESOLVE: q_cmd.kind = CMD_LOOKUP;
            ACT_SET:     q_cmd.kind = CMD_LEARN;
            ACT_FRAME: begin
                if (frame_ok) begin
                    q_cmd.kind     = CMD_LEARN;
                    q_cmd.frame_ok = 1'b1;
                    q_cmd.reply    = (s_item.opcode == OP_REQUEST) &&
                                     (s_item.tgt_ip == own_ip_reg);
                end else begin
                    q_cmd.kind = CMD_NOP;
                end
            end
            default:     q_cmd.kind = CMD_NOP;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/arpc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module arpc_queue (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  wire arpc_pkg::cmd_t cmd_in,
    output logic                full,
    input  wire                 pop,
    output arpc_pkg::cmd_t      cmd_out,
    output logic                not_empty,
    output logic [1:0]          level
);
    import arpc_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] level_reg;

    assign full      = (level_reg == 2'd2);
    assign not_empty = (level_reg != 2'd0);
    assign cmd_out   = slot_reg[rd_ptr_reg];
    assign level     = level_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                level_reg <= level_reg + 2'd1;
            end else if (pop && !push) begin
                level_reg <= level_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/arpc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module arpc_back #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 q_valid,
    input  wire arpc_pkg::cmd_t q_cmd,
    output logic                q_pop,
    output logic                m_valid,
    input  wire                 m_ready,
    output arpc_pkg::res_t      m_res
);
    import arpc_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_ACT  = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [IP_W-1:0]  ip_mem  [ENTRIES];
    logic [MAC_W-1:0] mac_mem [ENTRIES];
    logic [IP_W-1:0]  ip_rd_reg;
    logic [MAC_W-1:0] mac_rd_reg;

    logic [2:0]         state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic               found_reg, found_next;
    logic [IW-1:0]      match_reg, match_next;
    logic               free_found_reg, free_found_next;
    logic [IW-1:0]      free_reg, free_next;
    logic [IW-1:0]      ptr_reg, ptr_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    res_t               res_reg, res_next;
    res_t               out_reg, out_next;
    logic               m_valid_reg, m_valid_next;

    logic          ip_rd_en;
    logic          mac_rd_en;
    logic          mem_we;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          hit_now;

    assign rd_addr = cnt_reg[IW-1:0];
    assign hit_now = valid_reg[cmp_idx_reg] && (ip_rd_reg == cmd_reg.ip);
    assign m_valid = m_valid_reg;
    assign m_res   = out_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ip_mem[wr_addr] <= cmd_reg.ip;
        end
        if (ip_rd_en) begin
            ip_rd_reg <= ip_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mac_mem[wr_addr] <= cmd_reg.mac;
        end
        if (mac_rd_en) begin
            mac_rd_reg <= mac_mem[match_reg];
        end
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        cnt_next        = cnt_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        match_next      = match_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        ptr_next        = ptr_reg;
        valid_next      = valid_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        q_pop           = 1'b0;
        ip_rd_en        = 1'b0;
        mac_rd_en       = 1'b0;
        mem_we          = 1'b0;
        wr_addr         = ptr_reg;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop                   = 1'b1;
                    cmd_next                = q_cmd;
                    cnt_next                = '0;
                    cmp_vld_next            = 1'b0;
                    found_next              = 1'b0;
                    free_found_next         = 1'b0;
                    res_next                = '0;
                    res_next.frame_accepted = q_cmd.frame_ok;
                    res_next.reply_valid    = q_cmd.reply;
                    res_next.reply_mac      = q_cmd.reply ? q_cmd.mac : '0;
                    res_next.reply_ip       = q_cmd.reply ? q_cmd.ip : '0;
                    state_next = (q_cmd.kind == CMD_NOP) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (cmp_vld_reg) begin
                    if (hit_now && !found_reg) begin
                        found_next = 1'b1;
                        match_next = cmp_idx_reg;
                    end
                    if (!valid_reg[cmp_idx_reg] && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_next       = cmp_idx_reg;
                    end
                end
                if (cnt_reg == CW'(ENTRIES)) begin
                    cmp_vld_next = 1'b0;
                    state_next   = S_ACT;
                end else begin
                    ip_rd_en     = 1'b1;
                    cmp_idx_next = rd_addr;
                    cmp_vld_next = 1'b1;
                    cnt_next     = cnt_reg + CW'(1);
                end
            end
            S_ACT: begin
                if (cmd_reg.kind == CMD_LOOKUP) begin
                    if (found_reg) begin
                        mac_rd_en  = 1'b1;
                        state_next = S_READ;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    mem_we = 1'b1;
                    if (found_reg) begin
                        wr_addr = match_reg;
                    end else if (free_found_reg) begin
                        wr_addr              = free_reg;
                        valid_next[free_reg] = 1'b1;
                    end else begin
                        wr_addr             = ptr_reg;
                        valid_next[ptr_reg] = 1'b1;
                        ptr_next = (ptr_reg == IW'(ENTRIES - 1)) ? '0 : ptr_reg + IW'(1);
                    end
                    state_next = S_DONE;
                end
            end
            S_READ: begin
                res_next.hit     = 1'b1;
                res_next.mac_out = mac_rd_reg;
                state_next       = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            valid_reg   <= '0;
            ptr_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            valid_reg   <= valid_next;
            ptr_reg     <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        cnt_reg        <= cnt_next;
        cmp_vld_reg    <= cmp_vld_next;
        cmp_idx_reg    <= cmp_idx_next;
        found_reg      <= found_next;
        match_reg      <= match_next;
        free_found_reg <= free_found_next;
        free_reg       <= free_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/arp_cache_and_responder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ARP cache and responder. Each beat on s_ gives exactly one beat on m_. The front
// checks received frames and the reply condition and queues up to two commands; the
// back scans the table memory one entry a cycle, then acts in S_ACT (a learn writes
// the entry; a resolve that hits reads the MAC back in S_READ); a dropped frame or
// unused action skips the scan and goes straight to S_DONE. A finished result sits
// in the m_ register while the next item is accepted. Valid marks clear at reset;
// configuration writes are taken every cycle (cfg_ready is always high). Own MAC
// writes are accepted but not stored or used by any result.
module arp_cache_and_responder_top #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [1:0]                       s_action,
    input  wire  [arpc_pkg::IP_W-1:0]        s_ip_addr,
    input  wire  [arpc_pkg::MAC_W-1:0]       s_mac_addr,
    input  wire  [10:0]                      s_frame_length,
    input  wire  [15:0]                      s_hw_type,
    input  wire  [15:0]                      s_prot_type,
    input  wire  [7:0]                       s_hw_len,
    input  wire  [7:0]                       s_prot_len,
    input  wire  [15:0]                      s_opcode,
    input  wire  [arpc_pkg::IP_W-1:0]        s_tgt_ip,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic                             m_hit,
    output logic [arpc_pkg::MAC_W-1:0]       m_mac_out,
    output logic                             m_frame_accepted,
    output logic                             m_reply_valid,
    output logic [arpc_pkg::MAC_W-1:0]       m_reply_mac,
    output logic [arpc_pkg::IP_W-1:0]        m_reply_ip,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [arpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [arpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import arpc_pkg::*;

    item_t      s_item;
    cmd_t       push_cmd;
    cmd_t       pop_cmd;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_not_empty;
    logic [1:0] q_level;
    res_t       m_res;

    assign s_item.action       = s_action;
    assign s_item.ip_addr      = s_ip_addr;
    assign s_item.mac_addr     = s_mac_addr;
    assign s_item.frame_length = s_frame_length;
    assign s_item.hw_type      = s_hw_type;
    assign s_item.prot_type    = s_prot_type;
    assign s_item.hw_len       = s_hw_len;
    assign s_item.prot_len     = s_prot_len;
    assign s_item.opcode       = s_opcode;
    assign s_item.tgt_ip       = s_tgt_ip;

    arpc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_cmd     (push_cmd),
        .q_push    (q_push),
        .q_full    (q_full)
    );

    arpc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .cmd_in    (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .cmd_out   (pop_cmd),
        .not_empty (q_not_empty),
        .level     (q_level)
    );

    arpc_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_not_empty),
        .q_cmd   (pop_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_hit            = m_res.hit;
    assign m_mac_out        = m_res.mac_out;
    assign m_frame_accepted = m_res.frame_accepted;
    assign m_reply_valid    = m_res.reply_valid;
    assign m_reply_mac      = m_res.reply_mac;
    assign m_reply_ip       = m_res.reply_ip;

    a_queue_level: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level != 2'd3)
        else $error("command queue overrun");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_not_empty)
        else $error("pop from empty command queue");

    a_hit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_frame_accepted))
        else $error("resolve beat carries frame status");

    a_reply_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_reply_valid) |-> m_frame_accepted)
        else $error("reply for a dropped frame");

endmodule
`default_nettype wire
